// ----- design/wsdm_pkg.sv -----
// Shared constants, configuration record and curve table builders for the
// waveshaper/mix block. No dependencies; used by design/ files but wsdm_if.
package wsdm_pkg;

	// Curve table resolution: 2^CURVE_TABLE_BITS intervals, one extra end entry
	localparam int CURVE_TABLE_BITS = 8;
	localparam int TAB_N            = 1 << CURVE_TABLE_BITS;
	localparam int ROM_IDX_W        = CURVE_TABLE_BITS + 1;
	localparam int SIN_FB           = 16 - CURVE_TABLE_BITS;
	localparam int TANH_FB          = 18 - CURVE_TABLE_BITS;
	localparam int SIN_Q_W          = 18 + SIN_FB;
	localparam int TANH_Q_W         = 18 + TANH_FB;

	// Register file layout
	localparam int PADDR_W   = 5;
	localparam int REG_IDX_W = PADDR_W - 2;
	localparam logic [REG_IDX_W-1:0] REG_CURVE_MODE  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_DRIVE_GAIN  = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_FOLD_FACTOR = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_BIAS_OFFSET = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_WET_LEVEL   = 3'd4;

	// Curve select codes; the unused code behaves as hard clip
	localparam logic [1:0] CURVE_CLIP = 2'd0;
	localparam logic [1:0] CURVE_TANH = 2'd1;
	localparam logic [1:0] CURVE_FOLD = 2'd2;

	// Reset values
	localparam logic [15:0] DRIVE_RESET = 16'd4096;
	localparam logic [15:0] FOLD_RESET  = 16'd8192;
	localparam logic [15:0] WET_RESET   = 16'd16384;
	localparam logic [15:0] WET_ONE     = 16'd32768;

	localparam logic [63:0] ONE_Q30 = 64'd1 << 30;
	localparam logic [63:0] PI_Q30  = 64'd3373259426;

	typedef struct packed {
		logic [1:0]  curve_mode;
		logic [15:0] drive_gain;
		logic [15:0] fold_factor;
		logic [15:0] bias_offset;
		logic [15:0] wet_level;
	} wsdm_cfg_t;

	// Saturate a signed value to the Q1.15 range
	function automatic logic signed [15:0] sat16(input logic signed [35:0] v);
		logic signed [15:0] r;
		if (v > 36'sd32767) begin
			r = 16'sh7fff;
		end else if (v < -36'sd32768) begin
			r = 16'sh8000;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

	// Restoring long division, used only while building the curve tables
	function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
		logic [63:0] rem;
		logic [63:0] quo;
		rem = '0;
		quo = '0;
		for (int i = 63; i >= 0; i--) begin
			rem = {rem[62:0], num[i]};
			if (rem >= den) begin
				rem = rem - den;
				quo[i] = 1'b1;
			end
		end
		return quo;
	endfunction

	// tanh in Q30: short series on x/64, then six double-angle steps
	function automatic logic [63:0] tanh_q30(input logic [63:0] x);
		logic [63:0] h;
		logic [63:0] h2;
		logic [63:0] h3;
		logic [63:0] h5;
		logic [63:0] h7;
		logic [63:0] t;
		h  = x >> 6;
		h2 = (h * h) >> 30;
		h3 = (h2 * h) >> 30;
		h5 = (h3 * h2) >> 30;
		h7 = (h5 * h2) >> 30;
		t  = h + (64'd2 * h5) / 64'd15 - h3 / 64'd3 - (64'd17 * h7) / 64'd315;
		for (int i = 0; i < 6; i++) begin
			t = udiv64((64'd2 * t) << 30, ONE_Q30 + ((t * t) >> 30));
		end
		return t;
	endfunction

	// sine in Q30 over the first quadrant, power series to eight terms
	function automatic logic [63:0] sin_q30(input logic [63:0] a);
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] k2;
		logic signed [63:0] sum;
		x2   = (a * a) >> 30;
		term = a;
		sum  = $signed(a);
		for (int k = 1; k <= 7; k++) begin
			k2   = 64'(2 * k);
			term = udiv64((term * x2) >> 30, k2 * (k2 + 64'd1));
			if ((k % 2) == 1) begin
				sum = sum - $signed(term);
			end else begin
				sum = sum + $signed(term);
			end
		end
		return (sum < 0) ? 64'd0 : $unsigned(sum);
	endfunction

	function automatic logic [15:0] q30_to_q15(input logic [63:0] v);
		logic [63:0] r;
		r = (v + 64'd16384) >> 15;
		return (r > 64'd32767) ? 16'd32767 : r[15:0];
	endfunction

	function automatic logic [15:0] tanh_entry(input int k);
		return q30_to_q15(tanh_q30(64'(k) << (33 - CURVE_TABLE_BITS)));
	endfunction

	function automatic logic [15:0] sin_base(input int j);
		return q30_to_q15(sin_q30((PI_Q30 * 64'(j)) >> (CURVE_TABLE_BITS - 1)));
	endfunction

	// Full-turn sine table from the first quadrant by symmetry
	function automatic logic signed [15:0] sin_entry(input int k);
		logic signed [15:0] r;
		if (k <= TAB_N / 4) begin
			r = $signed(sin_base(k));
		end else if (k <= TAB_N / 2) begin
			r = $signed(sin_base(TAB_N / 2 - k));
		end else if (k <= (3 * TAB_N) / 4) begin
			r = -$signed(sin_base(k - TAB_N / 2));
		end else begin
			r = -$signed(sin_base(TAB_N - k));
		end
		return r;
	endfunction

endpackage

// ----- design/wsdm_if.sv -----
// Stream channel interfaces for the waveshaper/mix block: dry input samples
// and mixed output samples. Valid/ready handshake; no dependencies.
interface wsdm_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] sample_in;
	logic               last_in;

	modport source (output valid, output sample_in, output last_in, input ready);
	modport sink   (input valid, input sample_in, input last_in, output ready);
endinterface

interface wsdm_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] sample_out;
	logic               last_out;

	modport source (output valid, output sample_out, output last_out, input ready);
	modport sink   (input valid, input sample_out, input last_out, output ready);
endinterface

// ----- design/wsdm_regs.sv -----
// APB configuration registers for the waveshaper/mix block.
// Depends on wsdm_pkg for the register map and the configuration record.
module wsdm_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [wsdm_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	output wsdm_pkg::wsdm_cfg_t           cfg
);
	import wsdm_pkg::*;

	logic [REG_IDX_W-1:0] idx;
	logic                 wr_en;
	wsdm_cfg_t            cfg_q;

	assign idx    = paddr[PADDR_W-1:2];
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// Register writes; out-of-range indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.curve_mode  <= CURVE_CLIP;
			cfg_q.drive_gain  <= DRIVE_RESET;
			cfg_q.fold_factor <= FOLD_RESET;
			cfg_q.bias_offset <= '0;
			cfg_q.wet_level   <= WET_RESET;
		end else if (wr_en) begin
			unique case (idx)
				REG_CURVE_MODE:  cfg_q.curve_mode  <= pwdata[1:0];
				REG_DRIVE_GAIN:  cfg_q.drive_gain  <= pwdata[15:0];
				REG_FOLD_FACTOR: cfg_q.fold_factor <= pwdata[15:0];
				REG_BIAS_OFFSET: cfg_q.bias_offset <= pwdata[15:0];
				REG_WET_LEVEL:   cfg_q.wet_level   <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// Read-back mux
	always_comb begin
		unique case (idx)
			REG_CURVE_MODE:  prdata = {30'd0, cfg_q.curve_mode};
			REG_DRIVE_GAIN:  prdata = {16'd0, cfg_q.drive_gain};
			REG_FOLD_FACTOR: prdata = {16'd0, cfg_q.fold_factor};
			REG_BIAS_OFFSET: prdata = {16'd0, cfg_q.bias_offset};
			REG_WET_LEVEL:   prdata = {16'd0, cfg_q.wet_level};
			default:         prdata = '0;
		endcase
	end

endmodule

// ----- design/wsdm_curve_rom.sv -----
// Constant tanh and sine tables with two neighboring reads each, for
// linear interpolation. Depends on wsdm_pkg for the table builders.
module wsdm_curve_rom (
	input  logic [wsdm_pkg::CURVE_TABLE_BITS-1:0] sin_idx,
	input  logic [wsdm_pkg::CURVE_TABLE_BITS-1:0] tanh_idx,
	output logic signed [15:0]                    sin_lo,
	output logic signed [15:0]                    sin_hi,
	output logic [15:0]                           tanh_lo,
	output logic [15:0]                           tanh_hi
);
	import wsdm_pkg::*;

	logic signed [15:0]   sin_rom  [TAB_N+1];
	logic [15:0]          tanh_rom [TAB_N+1];
	logic [ROM_IDX_W-1:0] sin_a;
	logic [ROM_IDX_W-1:0] tanh_a;

	// Table contents are fixed at elaboration
	for (genvar k = 0; k <= TAB_N; k++) begin : g_rom
		localparam logic signed [15:0] SIN_V  = sin_entry(k);
		localparam logic [15:0]        TANH_V = tanh_entry(k);
		assign sin_rom[k]  = SIN_V;
		assign tanh_rom[k] = TANH_V;
	end

	assign sin_a  = {1'b0, sin_idx};
	assign tanh_a = {1'b0, tanh_idx};

	assign sin_lo  = sin_rom[sin_a];
	assign sin_hi  = sin_rom[sin_a + ROM_IDX_W'(1)];
	assign tanh_lo = tanh_rom[tanh_a];
	assign tanh_hi = tanh_rom[tanh_a + ROM_IDX_W'(1)];

endmodule

// ----- design/waveshaper_distortion_mix_unit.sv -----
// Top level of the waveshaper distortion with wet/dry mix.
// Depends on wsdm_pkg, wsdm_if, wsdm_regs and wsdm_curve_rom.
//
// Usage:
//  dry_ch carries one Q1.15 sample and a last flag per transaction; mix_ch
//  returns the shaped and mixed sample with the same last flag, in order.
//  The APB port sets curve mode, drive, fold depth, bias and wet level;
//  write it only while no sample is in flight.
//  A sample accepted on dry_ch passes through seven register stages (bias,
//  drive multiply, table read, interpolation, curve select, mix multiply,
//  round/saturate) before it is valid on mix_ch.
//  Throughput: one sample per clock while mix_ch is ready; no stage
//  chains two multiplies. A stalled receiver holds only the stages that
//  are full: dry_ch.ready stays high while any stage is empty, so bubbles
//  close up. Nothing is dropped or repeated.
//  Reset (arst_n low) empties the pipeline and loads the register defaults:
//  hard clip, drive 1.0, fold 0.5, bias 0, wet 0.5.
module waveshaper_distortion_mix_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	wsdm_in_if.sink                      dry_ch,
	wsdm_out_if.source                   mix_ch,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [wsdm_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);
	import wsdm_pkg::*;

	wsdm_cfg_t cfg;

	// Stage enables and valid bits
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6, en_s7;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;

	// Stage payloads
	logic signed [15:0] x_s1, x_s2, x_s3, x_s4, x_s5;
	logic signed [15:0] s_s1, s_s2, s_s3, s_s4;
	logic               last_s1, last_s2, last_s3, last_s4, last_s5, last_s6, last_s7;
	logic signed [20:0] p_s2, p_s3, p_s4;
	logic signed [15:0] sa_s2, sb_s2, sa_s3;
	logic [SIN_FB-1:0]  sfrac_s2;
	logic signed [SIN_Q_W-1:0] sq_s3;
	logic [15:0]        ta_s3, tb_s3, ta_s4;
	logic [TANH_FB-1:0] tfrac_s3;
	logic               neg_s3, neg_s4, tsat_s3, tsat_s4;
	logic signed [TANH_Q_W-1:0] tq_s4;
	logic signed [15:0] g_s4;
	logic signed [15:0] f_s5;
	logic signed [32:0] wm_s6, dm_s6;
	logic signed [15:0] y_s7;

	// Combinational nets
	logic signed [16:0] sum1;
	logic signed [32:0] prod2;
	logic signed [15:0] rom_sin_lo, rom_sin_hi;
	logic [15:0]        rom_tanh_lo, rom_tanh_hi;
	logic [20:0]        mag3;
	logic signed [16:0] sdiff3, tdiff4;
	logic signed [SIN_Q_W-1:0]  sq3, sqa4;
	logic signed [TANH_Q_W-1:0] tq4, tqa5;
	logic signed [17:0] g4;
	logic signed [17:0] y5;
	logic signed [15:0] ft5, ff5, fc5, f5;
	logic signed [31:0] fp5;
	logic signed [18:0] fd5;
	logic [15:0]        w_lvl, w_dry;
	logic signed [33:0] acc7;

	wsdm_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	wsdm_curve_rom u_rom (
		.sin_idx  (s_s1[15:SIN_FB]),
		.tanh_idx (mag3[17:TANH_FB]),
		.sin_lo   (rom_sin_lo),
		.sin_hi   (rom_sin_hi),
		.tanh_lo  (rom_tanh_lo),
		.tanh_hi  (rom_tanh_hi)
	);

	// A stage loads when it is empty or its content moves on
	assign en_s7 = !vld_s7 || mix_ch.ready;
	assign en_s6 = !vld_s6 || en_s7;
	assign en_s5 = !vld_s5 || en_s6;
	assign en_s4 = !vld_s4 || en_s5;
	assign en_s3 = !vld_s3 || en_s4;
	assign en_s2 = !vld_s2 || en_s3;
	assign en_s1 = !vld_s1 || en_s2;
	assign dry_ch.ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else begin
			if (en_s1) vld_s1 <= dry_ch.valid;
			if (en_s2) vld_s2 <= vld_s1;
			if (en_s3) vld_s3 <= vld_s2;
			if (en_s4) vld_s4 <= vld_s3;
			if (en_s5) vld_s5 <= vld_s4;
			if (en_s6) vld_s6 <= vld_s5;
			if (en_s7) vld_s7 <= vld_s6;
		end
	end

	// Stage 1: add bias, saturate
	assign sum1 = 17'(dry_ch.sample_in) + 17'($signed(cfg.bias_offset));

	always_ff @(posedge clk) begin
		if (en_s1) begin
			x_s1    <= dry_ch.sample_in;
			s_s1    <= sat16(36'(sum1));
			last_s1 <= dry_ch.last_in;
		end
	end

	// Stage 2: drive gain (floor to Q6.15), sine table read on the phase
	assign prod2 = 33'(s_s1) * 33'($signed({1'b0, cfg.drive_gain}));

	always_ff @(posedge clk) begin
		if (en_s2) begin
			x_s2     <= x_s1;
			s_s2     <= s_s1;
			last_s2  <= last_s1;
			p_s2     <= prod2[32:12];
			sa_s2    <= rom_sin_lo;
			sb_s2    <= rom_sin_hi;
			sfrac_s2 <= s_s1[SIN_FB-1:0];
		end
	end

	// Stage 3: tanh table read on |p|, sine slope times fraction
	assign mag3   = p_s2[20] ? 21'(-p_s2) : 21'(p_s2);
	assign sdiff3 = 17'(sb_s2) - 17'(sa_s2);
	assign sq3    = SIN_Q_W'(sdiff3) * SIN_Q_W'($signed({1'b0, sfrac_s2}));

	always_ff @(posedge clk) begin
		if (en_s3) begin
			x_s3     <= x_s2;
			s_s3     <= s_s2;
			last_s3  <= last_s2;
			p_s3     <= p_s2;
			sa_s3    <= sa_s2;
			sq_s3    <= sq3;
			ta_s3    <= rom_tanh_lo;
			tb_s3    <= rom_tanh_hi;
			tfrac_s3 <= mag3[TANH_FB-1:0];
			neg_s3   <= p_s2[20];
			tsat_s3  <= |mag3[20:18];
		end
	end

	// Stage 4: tanh slope times fraction, sine value (quotient toward zero)
	assign tdiff4 = 17'($signed({1'b0, tb_s3})) - 17'($signed({1'b0, ta_s3}));
	assign tq4    = TANH_Q_W'(tdiff4) * TANH_Q_W'($signed({1'b0, tfrac_s3}));
	assign sqa4   = sq_s3 + (sq_s3[SIN_Q_W-1] ? SIN_Q_W'((1 << SIN_FB) - 1) : SIN_Q_W'(0));
	assign g4     = 18'(sa_s3) + sqa4[SIN_Q_W-1:SIN_FB];

	always_ff @(posedge clk) begin
		if (en_s4) begin
			x_s4    <= x_s3;
			s_s4    <= s_s3;
			last_s4 <= last_s3;
			p_s4    <= p_s3;
			ta_s4   <= ta_s3;
			tq_s4   <= tq4;
			neg_s4  <= neg_s3;
			tsat_s4 <= tsat_s3;
			g_s4    <= g4[15:0];
		end
	end

	// Stage 5: finish each curve and pick one
	assign tqa5 = tq_s4 + (tq_s4[TANH_Q_W-1] ? TANH_Q_W'((1 << TANH_FB) - 1) : TANH_Q_W'(0));
	assign y5   = tsat_s4 ? 18'sd32767
		: 18'($signed({1'b0, ta_s4})) + tqa5[TANH_Q_W-1:TANH_FB];
	assign ft5  = neg_s4 ? -y5[15:0] : y5[15:0];
	assign fp5  = 32'($signed(cfg.fold_factor)) * 32'(g_s4);
	assign fd5  = 19'(s_s4) - 19'($signed(fp5[31:14]));
	assign ff5  = sat16(36'(fd5));
	assign fc5  = sat16(36'(p_s4));

	always_comb begin
		priority if (cfg.curve_mode == CURVE_TANH) begin
			f5 = ft5;
		end else if (cfg.curve_mode == CURVE_FOLD) begin
			f5 = ff5;
		end else begin
			f5 = fc5;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s5) begin
			x_s5    <= x_s4;
			last_s5 <= last_s4;
			f_s5    <= f5;
		end
	end

	// Stage 6: wet and dry products; wet level above one counts as one
	assign w_lvl = (cfg.wet_level > WET_ONE) ? WET_ONE : cfg.wet_level;
	assign w_dry = WET_ONE - w_lvl;

	always_ff @(posedge clk) begin
		if (en_s6) begin
			last_s6 <= last_s5;
			wm_s6   <= 33'(f_s5) * 33'($signed({1'b0, w_lvl}));
			dm_s6   <= 33'(x_s5) * 33'($signed({1'b0, w_dry}));
		end
	end

	// Stage 7: round, floor to Q1.15, saturate; output register
	assign acc7 = 34'(wm_s6) + 34'(dm_s6) + 34'sd16384;

	always_ff @(posedge clk) begin
		if (en_s7) begin
			last_s7 <= last_s6;
			y_s7    <= sat16(36'($signed(acc7[33:15])));
		end
	end

	assign mix_ch.valid      = vld_s7;
	assign mix_ch.sample_out = y_s7;
	assign mix_ch.last_out   = last_s7;

	// Checks on the pipeline control
	a_full_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && vld_s2 && vld_s3 && vld_s4 && vld_s5 && vld_s6 && vld_s7
			&& !mix_ch.ready) |-> !dry_ch.ready)
		else $error("input taken while every stage is full and stalled");

	a_bubble_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!vld_s7 |-> dry_ch.ready)
		else $error("input refused with an empty output stage");

	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(dry_ch.valid && dry_ch.ready) |=> vld_s1)
		else $error("accepted transaction missing from first stage");

	a_hold_mid: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s6 && !en_s7) |=> (vld_s6 && $stable(wm_s6) && $stable(dm_s6)))
		else $error("stalled mix products changed");

endmodule

// ----- dv/waveshaper_distortion_mix_unit_test.sv -----
// Self-checking testbench for waveshaper_distortion_mix_unit: directed table, then random phases.
// Builds its own tanh/sine tables and fixed-point shaper to predict each sample not given by hand.
// Depends on wsdm_pkg, wsdm_if and the RTL under design/.
`timescale 1ns / 1ps

module waveshaper_distortion_mix_unit_test;
	import wsdm_pkg::*;

	localparam int          PIPE_DEPTH   = 7;
	localparam int          CYCLE_LIMIT  = 200000;
	localparam int          PHASES       = 14;
	localparam int          PHASE_ITEMS  = 125;
	localparam int          HOLD_CYCLES  = 400;
	localparam int          REG_COUNT    = 5;
	localparam int          TANH_FRAC    = 18 - CURVE_TABLE_BITS;
	localparam int          SINE_FRAC    = 16 - CURVE_TABLE_BITS;
	localparam logic [1:0]  CURVE_SPARE  = 2'd3;
	localparam logic [15:0] WET_FULL     = 16'd32768;
	localparam longint unsigned ONE_FIX  = 64'd1 << 30;
	localparam longint unsigned PI_FIX   = 64'd3373259426;
	localparam logic [1:0]  MODE_ORDER [4] = '{CURVE_CLIP, CURVE_TANH, CURVE_FOLD, CURVE_SPARE};

	typedef struct packed {
		logic signed [15:0] smp;
		logic               lst;
	} mix_result_t;

	// One directed row: register settings, the dry sample, and an optional hand-computed result
	typedef struct packed {
		logic [1:0]  mode;
		logic [15:0] drive;
		logic [15:0] fold;
		logic [15:0] bias;
		logic [15:0] wet;
		logic [15:0] smp;
		logic        lst;
		logic        junk;
		logic        typed;
		logic [15:0] want;
	} shaper_case_t;

	localparam int DIR_N = 25;
	localparam shaper_case_t DIR_CASES [0:DIR_N-1] = '{
		// reset settings: hard clip, drive 1.0, wet 0.5
		'{CURVE_CLIP, 16'd4096, 16'd8192, 16'd0, 16'd16384, 16'd0, 1'b0, 1'b0, 1'b1, 16'd0},
		'{CURVE_CLIP, 16'd4096, 16'd8192, 16'd0, 16'd16384, 16'h7fff, 1'b1, 1'b0, 1'b1, 16'h7fff},
		'{CURVE_CLIP, 16'd4096, 16'd8192, 16'd0, 16'd16384, 16'h8000, 1'b0, 1'b0, 1'b1, 16'h8000},
		'{CURVE_CLIP, 16'd4096, 16'd8192, 16'd0, 16'd16384, 16'd1234, 1'b0, 1'b0, 1'b0, 16'd0},
		// dry only, fully wet, wet above one
		'{CURVE_TANH, 16'd4096, 16'd8192, 16'd0, 16'd0, 16'hfff9, 1'b1, 1'b0, 1'b1, 16'hfff9},
		'{CURVE_CLIP, 16'd4096, 16'd8192, 16'd0, WET_FULL, 16'd1000, 1'b0, 1'b0, 1'b1, 16'd1000},
		'{CURVE_CLIP, 16'd4096, 16'd8192, 16'd0, 16'hffff, 16'hfc18, 1'b0, 1'b0, 1'b1, 16'hfc18},
		// drive extremes
		'{CURVE_CLIP, 16'hffff, 16'd8192, 16'd0, WET_FULL, 16'd100, 1'b0, 1'b0, 1'b0, 16'd0},
		'{CURVE_CLIP, 16'hffff, 16'd8192, 16'd0, WET_FULL, 16'h7fff, 1'b1, 1'b0, 1'b1, 16'h7fff},
		'{CURVE_CLIP, 16'hffff, 16'd8192, 16'd0, WET_FULL, 16'h8000, 1'b0, 1'b0, 1'b1, 16'h8000},
		'{CURVE_CLIP, 16'd0, 16'd8192, 16'd0, WET_FULL, 16'd20000, 1'b0, 1'b0, 1'b1, 16'd0},
		// bias pushes the sum past both limits
		'{CURVE_CLIP, 16'd4096, 16'd8192, 16'h7fff, WET_FULL, 16'h7fff, 1'b0, 1'b0, 1'b1, 16'h7fff},
		'{CURVE_CLIP, 16'd4096, 16'd8192, 16'h8000, WET_FULL, 16'h8000, 1'b0, 1'b0, 1'b1, 16'h8000},
		// tanh: zero, beyond the table on both sides, mid range
		'{CURVE_TANH, 16'd4096, 16'd8192, 16'd0, WET_FULL, 16'd0, 1'b0, 1'b0, 1'b1, 16'd0},
		'{CURVE_TANH, 16'hffff, 16'd8192, 16'd0, WET_FULL, 16'h7fff, 1'b0, 1'b0, 1'b1, 16'h7fff},
		'{CURVE_TANH, 16'hffff, 16'd8192, 16'd0, WET_FULL, 16'h8000, 1'b1, 1'b0, 1'b1, 16'h8001},
		'{CURVE_TANH, 16'd4096, 16'd8192, 16'd0, WET_FULL, 16'd16384, 1'b0, 1'b0, 1'b0, 16'd0},
		'{CURVE_TANH, 16'd4096, 16'd8192, 16'd0, WET_FULL, 16'hc000, 1'b0, 1'b0, 1'b0, 16'd0},
		// sine fold: zero phase, fold depth extremes, negative bias
		'{CURVE_FOLD, 16'd4096, 16'd8192, 16'd0, WET_FULL, 16'd0, 1'b0, 1'b0, 1'b1, 16'd0},
		'{CURVE_FOLD, 16'd4096, 16'h8000, 16'd0, WET_FULL, 16'd16384, 1'b0, 1'b0, 1'b1, 16'h7fff},
		'{CURVE_FOLD, 16'd4096, 16'h7fff, 16'd0, WET_FULL, 16'hc000, 1'b0, 1'b0, 1'b0, 16'd0},
		'{CURVE_FOLD, 16'd4096, 16'd8192, 16'hfa24, 16'd16384, 16'd12000, 1'b1, 1'b0, 1'b0, 16'd0},
		// unused curve code behaves as clip; writes past the last register change nothing
		'{CURVE_SPARE, 16'd4096, 16'd8192, 16'd0, WET_FULL, 16'd555, 1'b0, 1'b0, 1'b1, 16'd555},
		'{CURVE_SPARE, 16'd4096, 16'd8192, 16'd0, WET_FULL, 16'd555, 1'b0, 1'b1, 1'b1, 16'd555},
		'{CURVE_FOLD, 16'd4096, 16'd8192, 16'd0, 16'd0, 16'h8000, 1'b1, 1'b0, 1'b1, 16'h8000}
	};

	logic                 clk;
	logic                 arst_n;
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [PADDR_W-1:0]   paddr;
	logic [31:0]          pwdata;
	logic [31:0]          prdata;
	logic                 pready;

	wsdm_in_if  dry_ch();
	wsdm_out_if mix_ch();

	waveshaper_distortion_mix_unit uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.dry_ch  (dry_ch),
		.mix_ch  (mix_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Shadow of the register file
	logic [1:0]         cur_mode;
	logic [15:0]        cur_drive;
	logic signed [15:0] cur_fold;
	logic signed [15:0] cur_bias;
	logic [15:0]        cur_wet;

	int tanh_lut [0:TAB_N];
	int sine_lut [0:TAB_N];

	mix_result_t        mix_expect [$];
	int                 bad_mix_cnt = 0;
	int unsigned        cycle_cnt = 0;
	int                 idle_pct = 38;
	int                 hold_req = 0;
	logic               side_typed;
	logic signed [15:0] side_want;

	always #1 clk = ~clk;

	// tanh in Q30: series on x/64, then six double-angle steps
	function automatic longint unsigned tanh_fix(input longint unsigned x);
		longint unsigned h, h2, h3, h5, h7, t;
		h  = x >> 6;
		h2 = (h * h) >> 30;
		h3 = (h2 * h) >> 30;
		h5 = (h3 * h2) >> 30;
		h7 = (h5 * h2) >> 30;
		t  = h + (64'd2 * h5) / 64'd15 - h3 / 64'd3 - (64'd17 * h7) / 64'd315;
		for (int k = 0; k < 6; k++)
			t = ((64'd2 * t) << 30) / (ONE_FIX + ((t * t) >> 30));
		return t;
	endfunction

	// first-quadrant sine in Q30, eight series terms
	function automatic longint unsigned sine_fix(input longint unsigned a);
		longint unsigned x2, term;
		longint          sum;
		x2   = (a * a) >> 30;
		term = a;
		sum  = $signed(a);
		for (int k = 1; k <= 7; k++) begin
			term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
			if (k % 2 == 1) sum = sum - $signed(term);
			else sum = sum + $signed(term);
		end
		return (sum < 0) ? 64'd0 : $unsigned(sum);
	endfunction

	function automatic int to_q15(input longint unsigned v);
		longint unsigned r;
		r = (v + 64'd16384) >> 15;
		return (r > 64'd32767) ? 32767 : int'(r);
	endfunction

	function automatic longint clamp16(input longint v);
		if (v > 32767) return 32767;
		if (v < -32768) return -32768;
		return v;
	endfunction

	// table interpolation, correction truncated toward zero
	function automatic int lerp(input int lo, input int hi, input longint frac, input int fb);
		longint q;
		q = longint'(hi - lo) * frac;
		if (q >= 0) q = q >>> fb;
		else q = -((-q) >>> fb);
		return lo + int'(q);
	endfunction

	// Bias, drive, curve and wet/dry mix for one dry sample under the current settings
	function automatic mix_result_t shape_and_mix(input logic signed [15:0] dry, input logic lst);
		longint      x, s, p, m, f, w, acc, prod, ph;
		int          y, g, idx;
		mix_result_t r;
		x = longint'(dry);
		s = clamp16(x + longint'(cur_bias));
		p = (s * longint'(cur_drive)) >>> 12;
		case (cur_mode)
			CURVE_TANH: begin
				m = (p < 0) ? -p : p;
				if (m >= (longint'(1) << 18)) begin
					y = 32767;
				end else begin
					idx = int'(m >> TANH_FRAC);
					y = lerp(tanh_lut[idx], tanh_lut[idx + 1], m & ((longint'(1) << TANH_FRAC) - 1),
						TANH_FRAC);
				end
				f = (p < 0) ? -longint'(y) : longint'(y);
			end
			CURVE_FOLD: begin
				ph   = s & 64'hffff;
				idx  = int'(ph >> SINE_FRAC);
				g    = lerp(sine_lut[idx], sine_lut[idx + 1], ph & ((longint'(1) << SINE_FRAC) - 1),
					SINE_FRAC);
				prod = (longint'(cur_fold) * longint'(g)) >>> 14;
				f    = clamp16(s - prod);
			end
			default: f = clamp16(p);
		endcase
		w     = (cur_wet > WET_FULL) ? 64'sd32768 : longint'(cur_wet);
		acc   = w * f + (64'sd32768 - w) * x + 64'sd16384;
		r.smp = 16'(clamp16(acc >>> 15));
		r.lst = lst;
		return r;
	endfunction

	// APB write: setup then access phase; shadow updated alongside
	task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [31:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_CURVE_MODE:  cur_mode  = val[1:0];
			REG_DRIVE_GAIN:  cur_drive = val[15:0];
			REG_FOLD_FACTOR: cur_fold  = val[15:0];
			REG_BIAS_OFFSET: cur_bias  = val[15:0];
			REG_WET_LEVEL:   cur_wet   = val[15:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic apply_cfg(input logic [1:0] mode, input logic [15:0] drive,
			input logic [15:0] fold, input logic [15:0] bias, input logic [15:0] wet, input bit noisy);
		logic [31:0] upper;
		upper = noisy ? $urandom : 32'd0;
		reg_write(REG_CURVE_MODE, {upper[31:2], mode});
		reg_write(REG_DRIVE_GAIN, {upper[31:16], drive});
		reg_write(REG_FOLD_FACTOR, {upper[31:16], fold});
		reg_write(REG_BIAS_OFFSET, {upper[31:16], bias});
		reg_write(REG_WET_LEVEL, {upper[31:16], wet});
	endtask

	// Offer one dry sample after a random gap; returns at the accepting edge
	task automatic offer_dry(input logic [15:0] smp, input logic lst, input logic typed,
			input logic [15:0] want);
		while ($urandom_range(99) < idle_pct) begin
			dry_ch.valid <= 1'b0;
			@(posedge clk);
		end
		dry_ch.valid     <= 1'b1;
		dry_ch.sample_in <= smp;
		dry_ch.last_in   <= lst;
		side_typed       <= typed;
		side_want        <= want;
		@(posedge clk);
		while (!dry_ch.ready) @(posedge clk);
	endtask

	// Stop offering and wait for every outstanding sample to come back
	task automatic drain();
		dry_ch.valid <= 1'b0;
		@(posedge clk);
		while (mix_expect.size() != 0) @(posedge clk);
		repeat (PIPE_DEPTH + 3) @(posedge clk);
	endtask

	// Receiver: random backpressure, plus a long hold whenever one is requested
	initial begin : mix_ready_gen
		int hold_seen;
		int hold_left;
		hold_seen    = 0;
		hold_left    = 0;
		mix_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				mix_ch.ready <= 1'b0;
			end else begin
				mix_ch.ready <= ($urandom_range(99) >= idle_pct);
			end
		end
	end

	// Scoreboard: predict on each accepted dry transaction, compare each mix transaction
	always @(posedge clk) begin : mix_scoreboard
		mix_result_t want;
		mix_result_t got;
		if (arst_n) begin
			if (dry_ch.valid && dry_ch.ready) begin
				want = shape_and_mix(dry_ch.sample_in, dry_ch.last_in);
				if (side_typed) want.smp = side_want;
				mix_expect.push_back(want);
			end
			if (mix_ch.valid && mix_ch.ready) begin
				got.smp = mix_ch.sample_out;
				got.lst = mix_ch.last_out;
				if (mix_expect.size() == 0) begin
					bad_mix_cnt++;
					if (bad_mix_cnt <= 10)
						$display("unexpected mix transaction: sample %0d last %0b", got.smp, got.lst);
				end else begin
					want = mix_expect.pop_front();
					if (got.smp !== want.smp || got.lst !== want.lst) begin
						bad_mix_cnt++;
						if (bad_mix_cnt <= 10)
							$display("mix mismatch: sample exp %0d got %0d, last exp %0b got %0b",
								want.smp, got.smp, want.lst, got.lst);
					end
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("waveshaper_distortion_mix_unit_test: FAIL");
			$finish;
		end
	end

	// Main sequence
	initial begin
		shaper_case_t       c;
		logic [1:0]         mode;
		logic [15:0]        drive, fold, bias, wet, smp;
		int                 v;

		clk              = 1'b0;
		arst_n           = 1'b0;
		psel             = 1'b0;
		penable          = 1'b0;
		pwrite           = 1'b0;
		paddr            = '0;
		pwdata           = '0;
		dry_ch.valid     = 1'b0;
		dry_ch.sample_in = '0;
		dry_ch.last_in   = 1'b0;
		side_typed       = 1'b0;
		side_want        = '0;
		cur_mode         = CURVE_CLIP;
		cur_drive        = 16'd4096;
		cur_fold         = 16'sd8192;
		cur_bias         = 16'sd0;
		cur_wet          = 16'd16384;

		// curve tables: tanh over [0,8), full-turn sine built from one quadrant
		for (int k = 0; k <= TAB_N; k++)
			tanh_lut[k] = to_q15(tanh_fix(64'(k) << (33 - CURVE_TABLE_BITS)));
		for (int k = 0; k <= TAB_N / 4; k++) begin
			v = to_q15(sine_fix((PI_FIX * 64'(k)) >> (CURVE_TABLE_BITS - 1)));
			sine_lut[k]             = v;
			sine_lut[TAB_N / 2 - k] = v;
			sine_lut[TAB_N / 2 + k] = -v;
			sine_lut[TAB_N - k]     = -v;
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table
		for (int i = 0; i < DIR_N; i++) begin
			c = DIR_CASES[i];
			if (c.mode != cur_mode || c.drive != cur_drive || c.fold != cur_fold ||
					c.bias != cur_bias || c.wet != cur_wet || c.junk) begin
				drain();
				if (c.mode != cur_mode || c.drive != cur_drive || c.fold != cur_fold ||
						c.bias != cur_bias || c.wet != cur_wet)
					apply_cfg(c.mode, c.drive, c.fold, c.bias, c.wet, 1'b0);
				if (c.junk)
					for (int j = REG_COUNT; j < (1 << REG_IDX_W); j++)
						reg_write(REG_IDX_W'(j), $urandom);
			end
			offer_dry(c.smp, c.lst, c.typed, c.want);
		end

		// Random phases, one register setting each
		for (int ph = 0; ph < PHASES; ph++) begin
			drain();
			mode = MODE_ORDER[ph % 4];
			case ($urandom_range(5))
				0: drive = 16'd0;
				1: drive = 16'hffff;
				2: drive = 16'd4096;
				3, 4: drive = 16'($urandom_range(0, 16383));
				default: drive = 16'($urandom);
			endcase
			case ($urandom_range(3))
				0: fold = 16'h8000;
				1: fold = 16'h7fff;
				default: fold = 16'($urandom);
			endcase
			case ($urandom_range(3))
				0: bias = 16'd0;
				1: bias = 16'($urandom_range(0, 4095) - 2048);
				2: bias = 16'($urandom);
				default: bias = $urandom_range(1) ? 16'h7fff : 16'h8000;
			endcase
			case ($urandom_range(5))
				0: wet = 16'd0;
				1: wet = WET_FULL;
				2: wet = 16'($urandom_range(32769, 65535));
				default: wet = 16'($urandom_range(0, 32768));
			endcase
			// last two phases sit at the corners of the register ranges
			if (ph == PHASES - 2) begin
				drive = 16'hffff;
				fold  = 16'h8000;
				bias  = 16'h7fff;
				wet   = WET_FULL;
			end else if (ph == PHASES - 1) begin
				drive = 16'hffff;
				fold  = 16'h7fff;
				bias  = 16'h8000;
				wet   = 16'hffff;
			end
			apply_cfg(mode, drive, fold, bias, wet, 1'b1);
			idle_pct = (ph == 5) ? 0 : 38;

			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// long receiver stall while samples keep coming
				if (ph == 3 && n == 20) hold_req++;
				// sender pause until the pipeline is empty
				if (ph == 8 && n == 60) drain();
				case ($urandom_range(9))
					0: smp = 16'h7fff;
					1: smp = 16'h8000;
					2: smp = 16'($urandom_range(0, 511) - 256);
					default: smp = 16'($urandom);
				endcase
				offer_dry(smp, ($urandom_range(7) == 0), 1'b0, 16'd0);
			end
		end

		drain();
		repeat (2 * PIPE_DEPTH) @(posedge clk);
		if (bad_mix_cnt == 0 && mix_expect.size() == 0)
			$display("waveshaper_distortion_mix_unit_test: PASS");
		else
			$display("waveshaper_distortion_mix_unit_test: FAIL");
		$finish;
	end

endmodule

// ----- waveshaper_distortion_mix_unit.f -----
design/wsdm_pkg.sv
design/wsdm_if.sv
design/wsdm_regs.sv
design/wsdm_curve_rom.sv
design/waveshaper_distortion_mix_unit.sv
dv/waveshaper_distortion_mix_unit_test.sv
